>>> src/sitda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W     = 4 * NUM_DIGITS;
	localparam int unsigned CHAR_W    = 6;
	localparam int unsigned LEN_W     = 4;
	localparam int unsigned IDX_W     = 4;
	localparam int unsigned BITCNT_W  = 5;

	localparam logic [CHAR_W-1:0]   CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0]   CHAR_MINUS = 6'd45;
	localparam logic [BITCNT_W-1:0] LAST_BIT   = 5'd31;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic shift;
		logic count;
		logic emit_sign;
		logic emit_digit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic conv_done;
		logic negative;
		logic last_digit;
	} dp_status_t;

endpackage

>>> src/signed_int_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Renders a signed 32-bit integer as decimal ASCII, one character per beat.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. The core then runs a
// bit-serial binary to BCD conversion, counts the digits, and emits the text
// most significant character first ('-' first for a negative value), one beat
// per cycle on valid. Each beat is shown for one cycle only and the receiver
// cannot stall it, so it must take every beat.
// Every beat carries the run's text_length; last marks the final character.
// text_length ranges from 1 to 11. busy falls in the cycle that shows
// the final beat, so the next value may be taken at that edge.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core
	import sitda_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      valid,
	output logic [CHAR_W-1:0]         character,
	output logic                      last,
	output logic [LEN_W-1:0]          text_length
);

	dp_cmd_t    cmd;
	dp_status_t status;

	sitda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	sitda_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.cmd         (cmd),
		.status      (status),
		.valid       (valid),
		.character   (character),
		.last        (last),
		.text_length (text_length)
	);

endmodule

>>> src/sitda_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: conversion, digit count, then one character beat per cycle.
// ----------------------------------------------------------------------------
module sitda_ctrl
	import sitda_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CONV  = 5'b00010,
		S_COUNT = 5'b00100,
		S_SIGN  = 5'b01000,
		S_DIGIT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CONV;
				end
			end
			S_CONV: begin
				cmd.shift = 1'b1;
				if (status.conv_done) begin
					state_d = S_COUNT;
				end
			end
			S_COUNT: begin
				cmd.count = 1'b1;
				state_d   = status.negative ? S_SIGN : S_DIGIT;
			end
			S_SIGN: begin
				cmd.emit_sign = 1'b1;
				state_d       = S_DIGIT;
			end
			S_DIGIT: begin
				cmd.emit_digit = 1'b1;
				if (status.last_digit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> src/sitda_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude, bit-serial binary to BCD, digit count, result register.
// ----------------------------------------------------------------------------
module sitda_dp
	import sitda_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [VALUE_W-1:0] value,
	input  dp_cmd_t                   cmd,
	output dp_status_t                status,
	output logic                      valid,
	output logic [CHAR_W-1:0]         character,
	output logic                      last,
	output logic [LEN_W-1:0]          text_length
);

	logic [VALUE_W-1:0]  mag_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [BCD_W-1:0]    bcd_adj;
	logic [BITCNT_W-1:0] bit_cnt_q;
	logic                neg_q;
	logic [LEN_W-1:0]    len_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    ndig;
	logic [3:0]          cur_digit;
	logic                valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;
	logic [LEN_W-1:0]    tlen_q;

	// add 3 to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// highest non-zero digit sets the count; zero still gives one digit
	always_comb begin
		ndig = 4'd1;
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				ndig = IDX_W'(i + 1);
			end
		end
	end

	assign cur_digit = bcd_q[{idx_q, 2'b00} +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			idx_q     <= '0;
			neg_q     <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= cmd.emit_sign | cmd.emit_digit;
			if (cmd.load) begin
				bit_cnt_q <= '0;
				neg_q     <= value[VALUE_W-1];
			end else if (cmd.shift) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			if (cmd.count) begin
				idx_q <= ndig - 1'b1;
			end else if (cmd.emit_digit) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= value[VALUE_W-1] ? (~value + 1'b1) : value;
			bcd_q <= '0;
		end else if (cmd.shift) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
		end
		if (cmd.count) begin
			len_q <= ndig + {{(LEN_W-1){1'b0}}, neg_q};
		end
		if (cmd.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
			tlen_q <= len_q;
		end else if (cmd.emit_digit) begin
			char_q <= CHAR_ZERO + {{(CHAR_W-4){1'b0}}, cur_digit};
			last_q <= (idx_q == '0);
			tlen_q <= len_q;
		end
	end

	assign status.conv_done  = (bit_cnt_q == LAST_BIT);
	assign status.negative   = neg_q;
	assign status.last_digit = (idx_q == '0);

	assign valid       = valid_q;
	assign character   = char_q;
	assign last        = last_q;
	assign text_length = tlen_q;

endmodule

>>> tb/signed_int_to_decimal_ascii_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_test
// Self-checking bench for the signed integer to decimal ASCII core.
// ----------------------------------------------------------------------------
// Values are sent on the start/busy handshake with random gaps. Each accepted
// value is rendered into its expected character beats here; a monitor checks
// every valid beat (character, last, text_length) against the oldest one.
// Directed values cover zero, the extremes and the digit-count boundaries;
// random values are spread over every magnitude and both signs.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_test;
	import sitda_pkg::*;

	localparam int unsigned RADIX       = 10;
	localparam int          NUM_RANDOM  = 138;
	localparam int          SETTLE      = 60;
	localparam longint      CYCLE_LIMIT = 200000;

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              is_last;
		logic [LEN_W-1:0]  length;
	} text_char_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [VALUE_W-1:0] value;
	logic                      valid;
	logic [CHAR_W-1:0]         character;
	logic                      last;
	logic [LEN_W-1:0]          text_length;

	text_char_t pending_chars[$];
	int         mismatches  = 0;
	longint     cycle_count = 0;

	signed_int_to_decimal_ascii_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.valid       (valid),
		.character   (character),
		.last        (last),
		.text_length (text_length)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// Render one value into its expected beats, most significant first.
	function automatic void queue_decimal_text(input logic [VALUE_W-1:0] bits);
		logic               negative;
		logic [VALUE_W-1:0] magnitude;
		logic [3:0]         digit [NUM_DIGITS];
		int                 ndigits;
		logic [LEN_W-1:0]   length;
		text_char_t         ch;
		negative  = bits[VALUE_W-1];
		magnitude = negative ? (~bits + 1'b1) : bits;
		ndigits   = 0;
		do begin
			digit[ndigits] = 4'(magnitude % RADIX);
			magnitude      = magnitude / RADIX;
			ndigits++;
		end while (magnitude != 0 && ndigits < NUM_DIGITS);
		length = LEN_W'(ndigits + (negative ? 1 : 0));
		if (negative) begin
			ch = '{CHAR_MINUS, 1'b0, length};
			pending_chars.push_back(ch);
		end
		for (int i = ndigits; i > 0; i--) begin
			ch = '{CHAR_ZERO + CHAR_W'(digit[i-1]), 1'(i == 1), length};
			pending_chars.push_back(ch);
		end
	endfunction

	// Check every beat against the oldest expectation.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && valid) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, character %0d", character));
			end else begin
				want = pending_chars.pop_front();
				if (character !== want.code)
					report_mismatch($sformatf("character %0d, expected %0d",
						character, want.code));
				if (last !== want.is_last)
					report_mismatch($sformatf("last %b, expected %b (character %0d)",
						last, want.is_last, want.code));
				if (text_length !== want.length)
					report_mismatch($sformatf("text_length %0d, expected %0d",
						text_length, want.length));
			end
		end
	end

	// Raise start with a value and hold it until the value is taken.
	task automatic send_value(input logic [VALUE_W-1:0] v);
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		queue_decimal_text(v);
	endtask

	// Drop start for a number of cycles; value carries noise meanwhile.
	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			value <= $urandom;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(20, 70);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		longint scale;
		longint mag;
		int     k;
		k     = $urandom_range(1, 9);
		scale = 1;
		repeat (k) scale = scale * RADIX;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: mag = $urandom_range(0, 32'(scale - 1));
			2: mag = scale + $urandom_range(0, 2) - 1;
			default: begin
				// stay near the ends of the range
				if ($urandom_range(0, 1))
					return 32'h7fff_ffff - $urandom_range(0, 20);
				return 32'h8000_0000 + $urandom_range(0, 20);
			end
		endcase
		if ($urandom_range(0, 1))
			mag = -mag;
		return VALUE_W'(mag);
	endfunction

	task automatic test_directed_values();
		logic [VALUE_W-1:0] directed [23] = '{
			32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
			32'd100, -32'sd100, 32'd1234567890, -32'sd987654321, 32'd999999999,
			-32'sd999999999, 32'd1000000000, -32'sd1000000000, 32'h7fff_ffff,
			32'h8000_0001, 32'h8000_0000, 32'd5, 32'd12345, -32'sd12345,
			32'h8000_0000
		};
		foreach (directed[i]) begin
			send_value(directed[i]);
			// run the first few back to back
			if (i >= 4)
				idle_sender(pick_gap());
		end
	endtask

	task automatic test_random_values();
		int sent;
		sent = 0;
		while (sent < NUM_RANDOM) begin
			send_value(pick_value());
			sent++;
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(3, 8)) begin
					send_value(pick_value());
					sent++;
				end
			end else begin
				idle_sender(pick_gap());
			end
		end
	endtask

	// Hold off until the core has emptied, then resume.
	task automatic test_drain_pause();
		repeat (4) send_value(pick_value());
		wait_drained();
		send_value(32'h8000_0000);
		wait_drained();
		repeat (4) send_value(pick_value());
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_values();
		test_drain_pause();
		test_random_values();

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
